@@ rtl/ftn_pkg.sv @@
package ftn_pkg;

  // Defaults for the top level parameters
  localparam int TOP_OCTAVE_DEF  = 12;
  localparam int FREQ_FRAC_DEF   = 14;

  // Fixed field and datapath widths
  localparam int FREQ_W    = 32;
  localparam int REF_W     = 23;
  localparam int EXP_W     = 5;
  localparam int LOG_FRAC  = 24;
  localparam int LOG_W     = EXP_W + LOG_FRAC;
  localparam int CM_W      = 22;
  localparam int CENTS_W   = 14;

  // Register index of the reference pitch
  localparam logic REG_REFERENCE_PITCH = 1'b0;

  // Both log2 results of one word
  typedef struct packed {
    logic             zero;
    logic [LOG_W-1:0] lf;
    logic [LOG_W-1:0] lr;
  } ftn_log_t;

  // Magnitude and sign of the offset in hundredths of a cent
  typedef struct packed {
    logic            zero;
    logic            neg;
    logic [CM_W-1:0] cm;
  } ftn_cents_t;

endpackage

@@ rtl/ftn_log2.sv @@
module ftn_log2 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [ftn_pkg::FREQ_W-1:0] freq,
  input  logic [ftn_pkg::REF_W-1:0]  refp,
  output logic                       out_vld,
  output ftn_pkg::ftn_log_t          out_log
);
  import ftn_pkg::*;

  // Entry and exponent stages
  logic [FREQ_W-1:0] x_f, x_r, x_f1, x_r1;
  logic              z0, z1, v0, v1;
  logic [EXP_W-1:0]  e_f1, e_r1, e_f1_next, e_r1_next;

  // Squaring stages, index 0 is the normalized mantissa
  logic [FREQ_W-1:0]   m_f [0:LOG_FRAC];
  logic [FREQ_W-1:0]   m_r [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] fr_f [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] fr_r [0:LOG_FRAC];
  logic [EXP_W-1:0]    ef [0:LOG_FRAC];
  logic [EXP_W-1:0]    er [0:LOG_FRAC];
  logic                zz [0:LOG_FRAC];
  logic                vv [0:LOG_FRAC];

  function automatic logic [EXP_W-1:0] msb_index(input logic [FREQ_W-1:0] x);
    logic [EXP_W-1:0] e;
    e = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (x[i]) e = EXP_W'(i);
    end
    return e;
  endfunction

  // One squaring step: returns the new fraction bit over the new mantissa
  function automatic logic [FREQ_W:0] sq_step(input logic [FREQ_W-1:0] m);
    logic [2*FREQ_W-1:0] sq;
    sq = {{FREQ_W{1'b0}}, m} * {{FREQ_W{1'b0}}, m};
    if (sq[2*FREQ_W-1]) begin
      return {1'b1, sq[2*FREQ_W-1:FREQ_W]};
    end else begin
      return {1'b0, sq[2*FREQ_W-2:FREQ_W-1]};
    end
  endfunction

  always_comb begin
    e_f1_next = msb_index(x_f);
    e_r1_next = msb_index(x_r);
  end

  // Capture the word, then find the exponents
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      vv[0] <= 1'b0;
    end else if (en) begin
      v0 <= in_vld;
      v1 <= v0;
      vv[0] <= v1;
    end
    if (en) begin
      x_f  <= freq;
      x_r  <= FREQ_W'(refp);
      z0   <= (freq == '0) || (refp == '0);
      x_f1 <= x_f;
      x_r1 <= x_r;
      e_f1 <= e_f1_next;
      e_r1 <= e_r1_next;
      z1   <= z0;
      // Normalize the mantissas to Q1.31
      m_f[0]  <= x_f1 << (EXP_W'(FREQ_W - 1) - e_f1);
      m_r[0]  <= x_r1 << (EXP_W'(FREQ_W - 1) - e_r1);
      fr_f[0] <= '0;
      fr_r[0] <= '0;
      ef[0]   <= e_f1;
      er[0]   <= e_r1;
      zz[0]   <= z1;
    end
  end

  // Square the mantissas, one fraction bit per stage
  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
    logic [FREQ_W:0] sf, sr;
    always_comb begin
      sf = sq_step(m_f[k]);
      sr = sq_step(m_r[k]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k+1] <= 1'b0;
      end else if (en) begin
        vv[k+1] <= vv[k];
      end
      if (en) begin
        m_f[k+1]  <= sf[FREQ_W-1:0];
        m_r[k+1]  <= sr[FREQ_W-1:0];
        fr_f[k+1] <= {fr_f[k][LOG_FRAC-2:0], sf[FREQ_W]};
        fr_r[k+1] <= {fr_r[k][LOG_FRAC-2:0], sr[FREQ_W]};
        ef[k+1]   <= ef[k];
        er[k+1]   <= er[k];
        zz[k+1]   <= zz[k];
      end
    end
  end

  assign out_vld      = vv[LOG_FRAC];
  assign out_log.zero = zz[LOG_FRAC];
  assign out_log.lf   = {ef[LOG_FRAC], fr_f[LOG_FRAC]};
  assign out_log.lr   = {er[LOG_FRAC], fr_r[LOG_FRAC]};

endmodule

@@ rtl/ftn_cents.sv @@
module ftn_cents (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  ftn_pkg::ftn_log_t   in_log,
  output logic                out_vld,
  output ftn_pkg::ftn_cents_t out_cents
);
  import ftn_pkg::*;

  localparam int PROD_W = LOG_W + 17;

  logic               v1, v2, v3;
  logic               z1, z2, z3, n1, n2, n3;
  logic [LOG_W:0]     d_next;
  logic [LOG_W-1:0]   mag1;
  logic [PROD_W-1:0]  prod2;
  logic [PROD_W:0]    rnd_next;
  logic [CM_W-1:0]    cm3;

  always_comb begin
    d_next   = {1'b0, in_log.lf} - {1'b0, in_log.lr};
    rnd_next = {1'b0, prod2} + (PROD_W+1)'(1 << (LOG_FRAC - 1));
  end

  // Take the magnitude, scale by 120000, round off the log fraction
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      n1    <= d_next[LOG_W];
      mag1  <= d_next[LOG_W] ? LOG_W'(-d_next) : d_next[LOG_W-1:0];
      z1    <= in_log.zero;
      prod2 <= PROD_W'(mag1) * PROD_W'(120000);
      n2    <= n1;
      z2    <= z1;
      cm3   <= rnd_next[LOG_FRAC+CM_W-1:LOG_FRAC];
      n3    <= n2;
      z3    <= z2;
    end
  end

  assign out_vld        = v3;
  assign out_cents.zero = z3;
  assign out_cents.neg  = n3;
  assign out_cents.cm   = cm3;

endmodule

@@ rtl/ftn_note.sv @@
module ftn_note #(
  parameter int TOP_OCTAVE = ftn_pkg::TOP_OCTAVE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  ftn_pkg::ftn_cents_t         in_cents,
  output logic                        out_vld,
  output logic                        valid_res,
  output logic [3:0]                  semitone,
  output logic [3:0]                  octave,
  output logic signed [ftn_pkg::CENTS_W-1:0] cents
);
  import ftn_pkg::*;

  localparam int C_W     = CM_W + 1;
  localparam int Q_W     = 9;
  localparam int N_W     = Q_W + 1;
  localparam int KSHIFT  = 34;
  localparam longint KREC = (64'd1 << KSHIFT) / 64'd10000;
  localparam int QP_W    = CM_W + 21;
  localparam int LOW_OFF  = -57;
  localparam int HIGH_OFF = 12 * TOP_OCTAVE - 46;
  localparam logic signed [C_W-1:0] C_LO = C_W'(LOW_OFF * 10000 - 5000);
  localparam logic signed [C_W-1:0] C_HI = C_W'(HIGH_OFF * 10000 + 5000);
  localparam logic signed [N_W-1:0] N_LO = N_W'(LOW_OFF);
  localparam logic signed [N_W-1:0] N_HI = N_W'(HIGH_OFF);

  logic                    v1, v2, v3, v4;
  logic                    ok1, ok2, ok3;
  logic                    neg1, neg2;
  logic signed [C_W-1:0]   c_next, c1, c2;
  logic [CM_W-1:0]         x1, rem2;
  logic [QP_W-1:0]         qp1;
  logic [Q_W-1:0]          q0_2;
  logic [Q_W-1:0]          q_next;
  logic signed [N_W-1:0]   n_next;
  logic signed [C_W-1:0]   r_next;
  logic [7:0]              idx3;
  logic signed [CENTS_W-1:0] r3;
  logic [16:0]             oct_prod;
  logic [3:0]              oct_next;
  logic [7:0]              semi_next;

  always_comb begin
    c_next = in_cents.neg ? -C_W'(in_cents.cm) : C_W'(in_cents.cm);
  end

  // Rounded note offset, then clamp into the covered range
  always_comb begin
    q_next = (rem2 >= CM_W'(10000)) ? q0_2 + Q_W'(1) : q0_2;
    n_next = neg2 ? -N_W'(q_next) : N_W'(q_next);
    if (n_next < N_LO) n_next = N_LO;
    if (n_next > N_HI) n_next = N_HI;
    r_next = c2 - C_W'(n_next) * C_W'(10000);
  end

  // Split note index into octave and pitch class
  always_comb begin
    oct_prod  = {9'b0, idx3} * 17'd171;
    oct_next  = oct_prod[14:11];
    semi_next = idx3 - {4'b0, oct_next} * 8'd12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      // Range check and reciprocal multiply for the divide by 10000
      c1   <= c_next;
      neg1 <= in_cents.neg;
      ok1  <= !in_cents.zero && !(c_next < C_LO) && !(c_next > C_HI);
      x1   <= in_cents.cm + CM_W'(5000);
      qp1  <= QP_W'(in_cents.cm + CM_W'(5000)) * QP_W'(KREC);
      // Quotient estimate and its remainder
      q0_2 <= qp1[KSHIFT+Q_W-1:KSHIFT];
      rem2 <= x1 - CM_W'(qp1[KSHIFT+Q_W-1:KSHIFT]) * CM_W'(10000);
      c2   <= c1;
      neg2 <= neg1;
      ok2  <= ok1;
      // Note index and residual
      idx3 <= 8'(n_next - N_W'(LOW_OFF));
      r3   <= CENTS_W'(r_next);
      ok3  <= ok2;
      // Result register, zero fields when out of range
      valid_res <= ok3;
      semitone  <= ok3 ? semi_next[3:0] : 4'd0;
      octave    <= ok3 ? oct_next : 4'd0;
      cents     <= ok3 ? r3 : '0;
    end
  end

  assign out_vld = v4;

endmodule

@@ rtl/frequency_to_note_with_cents.sv @@
// Frequency to equal-tempered note converter. Each word carries a frequency in
// unsigned fixed point (FREQ_FRACTION_BITS fraction bits); the result is the
// nearest note as octave and pitch class (C = 0) plus the deviation in
// hundredths of a cent, measured against the reference_pitch register (APB
// address 0, same format, reset 440 Hz). Frequencies outside C0-50c to
// B(TOP_OCTAVE)+50c, and a zero frequency or reference, return valid_res = 0
// with zero fields. One word is accepted per cycle while the output is not
// stalled; the log2 unit squares the mantissa once per stage over 24 stages
// for 24 fraction bits. A stall at the output halts the whole pipeline.
// Write reference_pitch only while idle.
module frequency_to_note_with_cents #(
  parameter int TOP_OCTAVE         = ftn_pkg::TOP_OCTAVE_DEF,
  parameter int FREQ_FRACTION_BITS = ftn_pkg::FREQ_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ftn_pkg::FREQ_W-1:0]         frequency,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               valid_res,
  output logic [3:0]                         semitone,
  output logic [3:0]                         octave,
  output logic signed [ftn_pkg::CENTS_W-1:0] cents
);
  import ftn_pkg::*;

  localparam logic [REF_W-1:0] REF_RESET = REF_W'(440 << FREQ_FRACTION_BITS);

  logic [REF_W-1:0] reference_pitch;
  logic             adv;
  logic             log_vld, cents_vld;
  ftn_log_t         log_res;
  ftn_cents_t       cents_res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_pitch <= REF_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_REFERENCE_PITCH) begin
      reference_pitch <= pwdata[REF_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REFERENCE_PITCH) ? {{(32-REF_W){1'b0}}, reference_pitch}
                                                    : 32'd0;

  // Advance the pipeline unless a finished word waits
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  ftn_log2 u_log2 (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (in_valid),
    .freq    (frequency),
    .refp    (reference_pitch),
    .out_vld (log_vld),
    .out_log (log_res)
  );

  ftn_cents u_cents (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_vld    (log_vld),
    .in_log    (log_res),
    .out_vld   (cents_vld),
    .out_cents (cents_res)
  );

  ftn_note #(
    .TOP_OCTAVE (TOP_OCTAVE)
  ) u_note (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_vld    (cents_vld),
    .in_cents  (cents_res),
    .out_vld   (out_valid),
    .valid_res (valid_res),
    .semitone  (semitone),
    .octave    (octave),
    .cents     (cents)
  );

`ifndef NO_ASSERTIONS
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> semitone == 4'd0 && octave == 4'd0 && cents == '0)
    else $error("out of range word has nonzero fields");

  a_semitone: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> semitone <= 4'd11)
    else $error("pitch class out of range");

  a_cents: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> cents <= CENTS_W'(5000) && cents >= -CENTS_W'(5000))
    else $error("residual cents out of range");
`endif

endmodule

@@ tb/ftn_checker.sv @@
module ftn_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] frequency,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        valid_res,
  input  logic [3:0]  semitone,
  input  logic [3:0]  octave,
  input  logic signed [13:0] cents,
  output int          fail_count,
  output int          pending,
  output int          seen_in_range,
  output int          seen_out_range
);
  import ftn_pkg::*;

  localparam int TOP_OCT = 12;
  localparam longint LOW_NOTE  = -57;
  localparam longint HIGH_NOTE = 12 * TOP_OCT - 46;

  typedef struct {
    logic        ok;
    logic [3:0]  pc;
    logic [3:0]  oct;
    logic signed [13:0] dev;
  } note_t;

  note_t notes_due[$];
  logic [22:0] ref_pitch;

  // log2 with 24 fraction bits, mantissa refined by repeated squaring
  function automatic longint log2_q24(input logic [31:0] x);
    int unsigned msb;
    logic [63:0] m;
    logic [63:0] frac;
    msb = 0;
    frac = 0;
    for (int b = 0; b < 32; b++)
      if (x[b]) msb = b;
    m = 64'(x) << (31 - msb);
    for (int k = 0; k < 24; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return longint'((64'(msb) << 24) | frac);
  endfunction

  function automatic note_t nearest_note(input logic [31:0] f, input logic [22:0] rp);
    note_t res;
    longint d, c, n, r;
    logic [63:0] mag;
    longint unsigned idx;
    res = '{1'b0, 4'd0, 4'd0, 14'sd0};
    if (f == 0 || rp == 0) return res;
    d = log2_q24(f) - log2_q24({9'd0, rp});
    mag = d < 0 ? -d : d;
    mag = (mag * 120000 + (64'd1 << 23)) >> 24;
    c = d < 0 ? -longint'(mag) : longint'(mag);
    if (c < LOW_NOTE * 10000 - 5000 || c > HIGH_NOTE * 10000 + 5000) return res;
    mag = c < 0 ? -c : c;
    mag = (mag + 5000) / 10000;
    n = c < 0 ? -longint'(mag) : longint'(mag);
    if (n < LOW_NOTE) n = LOW_NOTE;
    if (n > HIGH_NOTE) n = HIGH_NOTE;
    r = c - n * 10000;
    idx = n + 57;
    res.ok = 1'b1;
    res.pc = 4'(idx % 12);
    res.oct = 4'(idx / 12);
    res.dev = 14'(r);
    return res;
  endfunction

  // track register writes, predict on accepted words, compare results
  always @(posedge clk) begin
    note_t want;
    if (rst) begin
      ref_pitch <= 23'(440 << 14);
      fail_count <= 0;
      seen_in_range <= 0;
      seen_out_range <= 0;
      notes_due.delete();
    end else begin
      if (psel && penable && pwrite && paddr == 3'd0)
        ref_pitch <= pwdata[22:0];
      if (in_valid && in_ready)
        notes_due.push_back(nearest_note(frequency, ref_pitch));
      if (out_valid && out_ready) begin
        if (notes_due.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = notes_due.pop_front();
          if (want.ok) seen_in_range <= seen_in_range + 1;
          else seen_out_range <= seen_out_range + 1;
          if (valid_res !== want.ok || semitone !== want.pc || octave !== want.oct ||
              cents !== want.dev) begin
            fail_count <= fail_count + 1;
            if (valid_res !== want.ok)
              $error("valid_res expected %0d actual %0d", want.ok, valid_res);
            if (semitone !== want.pc)
              $error("semitone expected %0d actual %0d", want.pc, semitone);
            if (octave !== want.oct)
              $error("octave expected %0d actual %0d", want.oct, octave);
            if (cents !== want.dev)
              $error("cents expected %0d actual %0d", want.dev, cents);
          end
        end
      end
    end
  end

  assign pending = notes_due.size();
endmodule

@@ tb/tb_frequency_to_note_with_cents.sv @@
module tb_frequency_to_note_with_cents;
  import ftn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] frequency = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic valid_res;
  logic [3:0] semitone, octave;
  logic signed [13:0] cents;
  logic stall_free = 1'b0;
  int fail_count, pending, seen_in_range, seen_out_range;

  always #5 clk = ~clk;

  frequency_to_note_with_cents dut (.*);

  ftn_checker u_checker (.*);

  // receiver: ready drops now and then, except during the stall-free stretch
  always @(posedge clk)
    out_ready <= stall_free || ($urandom_range(99) >= 7);

  // random frequency near the musical range, with occasional wide values
  function automatic logic [31:0] pick_frequency();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(32'd200000, 32'd500_000_000);
    if (sel < 80) return $urandom_range(32'd1000, 32'd300000);
    if (sel < 90) return 32'h8000_0000 | $urandom;
    return $urandom;
  endfunction

  task automatic send_word(input logic [31:0] f, input bit gaps);
    while (gaps && !stall_free && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    frequency <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reference(input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(REG_REFERENCE_PITCH) * 3'd4; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [31:0] refs [5];
    logic [31:0] edges [$];
    refs = '{32'd7208960, 32'd6553600, 32'd7864320, 32'hFF80_0001, 32'd1};
    edges = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7208960, 32'd267900, 32'd267950,
              32'd268000, 32'd275000, 32'd259000, 32'd260500, 32'd261000,
              32'd1_065_000_000, 32'd1_100_000_000, 32'd1_140_000_000,
              32'd3_604_480, 32'd14_417_920, 32'h5555_5555, 32'hAAAA_AAAA,
              32'd4_292_000, 32'd7_209_000, 32'd7_650_000};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, range edges, octave marks
    foreach (edges[i]) send_word(edges[i], 1'b0);
    drain();

    // random phases over several reference settings, the smallest included
    for (int p = 0; p < 5; p++) begin
      write_reference(refs[p]);
      for (int i = 0; i < 80; i++) begin
        if (p == 1 && i == 20) stall_free <= 1'b1;
        if (p == 1 && i == 60) stall_free <= 1'b0;
        if (i == 40) drain();
        send_word(pick_frequency(), 1'b1);
      end
      drain();
    end
    write_reference(32'd7208960);
    for (int i = 0; i < 20; i++) send_word(pick_frequency(), 1'b1);
    drain();

    $display("Covered directed edge frequencies and %0d random words over 6 references.",
             420);
    $display("Results in range: %0d, out of range: %0d.", seen_in_range, seen_out_range);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ frequency_to_note_with_cents.f @@
rtl/ftn_pkg.sv
rtl/ftn_log2.sv
rtl/ftn_cents.sv
rtl/ftn_note.sv
rtl/frequency_to_note_with_cents.sv
tb/ftn_checker.sv
tb/tb_frequency_to_note_with_cents.sv
